### rtl/pma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed memory array package
// Sizes, codes, state encoding and helper functions shared by the design.
// ----------------------------------------------------------------------------
package pma_pkg;

   localparam int MAX_CAPACITY = 4096;
   localparam int MIN_CAPACITY = 32;
   localparam int MAX_SEGMENTS = 256;
   localparam int STORE_DEPTH  = (MAX_CAPACITY > 1024) ? MAX_CAPACITY : 1024;

   localparam int KEY_W    = 64;
   localparam int PAIR_W   = 2 * KEY_W;
   localparam int ADDR_W   = $clog2(STORE_DEPTH);
   localparam int CNT_W    = $clog2(STORE_DEPTH + 1);
   localparam int SEG_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int SEGC_W   = $clog2(MAX_SEGMENTS + 1);
   localparam int MIN_CAP_LOG = $clog2(MIN_CAPACITY);
   localparam int MAX_CAP_LOG = $clog2(MAX_CAPACITY + 1) - 1;
   localparam int MAX_SEG_LOG = $clog2(MAX_SEGMENTS);
   localparam int SHIFT_W  = $clog2(MAX_CAP_LOG + 2);
   localparam int HEIGHT_W = $clog2(MAX_SEG_LOG + 2);
   localparam int DBASE_W  = 9;
   localparam int COUNT_W  = 13;
   localparam int CMP_W    = CNT_W + HEIGHT_W + DBASE_W + MAX_CAP_LOG + 8;

   localparam logic [DBASE_W-1:0] DBASE_RESET = 9'd192;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_RANGE  = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_MISS      = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_BAD_RANGE = 2'd3;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_LOC_TEST,
      S_LOC_FIRST,
      S_LOC_LAST,
      S_OP,
      S_INS_SHIFT,
      S_INS_PUT,
      S_LK_SCAN,
      S_REB_START,
      S_DENS_MUL,
      S_DENS_CMP,
      S_WIN_SUM,
      S_GA_SEG,
      S_GA_FILL,
      S_GA_ELEM,
      S_DI_SEG,
      S_DI_ELEM
   } state_type;

   // smallest r with 2**r >= x
   function automatic logic [SHIFT_W-1:0] ceil_log(input logic [SHIFT_W-1:0] x);
      logic [SHIFT_W-1:0] r;
      r = '0;
      for (int i = 0; i < SHIFT_W; i++) begin
         if ((32'd1 << i) < {{(32-SHIFT_W){1'b0}}, x}) r = SHIFT_W'(i + 1);
      end
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [SEG_W-1:0] seg,
                                                   input logic [SHIFT_W-1:0] sh,
                                                   input logic [CNT_W-1:0] off);
      return (ADDR_W'(seg) << sh) + off[ADDR_W-1:0];
   endfunction

endpackage

### rtl/packed_memory_array_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed memory array
// Sorted key/value store in gapped segments with insert, lookup and range sum.
// ----------------------------------------------------------------------------
// Lookup: binary search over the segments, then a scan of the chosen segment's slots.
// Insert: search plus a shift of the larger keys in the segment; a rebalance adds
//   a sum of segment fills and a move of the window's elements, a capacity doubling
//   the same over the whole array (each store has one read and one write port).
// Range sum: visits every segment and every stored element. One op at a time.
// After reset a clearing pass over the MAX_SEGMENTS fill counters holds busy high.
// ----------------------------------------------------------------------------
module packed_memory_array_top
   import pma_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_kind,
   input  logic signed [KEY_W-1:0]  req_key,
   input  logic signed [KEY_W-1:0]  req_value,
   input  logic signed [KEY_W-1:0]  req_high_key,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [KEY_W-1:0]  rsp_found_value,
   output logic [COUNT_W-1:0]       rsp_match_count,
   output logic signed [KEY_W-1:0]  rsp_key_total,
   output logic signed [KEY_W-1:0]  rsp_value_total,
   output logic signed [KEY_W-1:0]  rsp_first_in_range,
   output logic signed [KEY_W-1:0]  rsp_last_in_range,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [DBASE_W-1:0]       csr_data
);

   state_type state_ff, state_in;

   logic [1:0]              kind_ff, kind_in;
   logic signed [KEY_W-1:0] key_ff, key_in, val_ff, val_in, hi_ff, hi_in;
   logic [SHIFT_W-1:0]      capshift_ff, capshift_in, segshift_ff, segshift_in;
   logic [HEIGHT_W-1:0]     height_ff, height_in;
   logic [CNT_W-1:0]        ecount_ff, ecount_in;
   logic [DBASE_W-1:0]      dbase_ff, dbase_in;
   logic [SEG_W-1:0]        lb_ff, lb_in, ub_ff, ub_in, p_ff, p_in, seg_ff, seg_in;
   logic [SEG_W-1:0]        clr_ff, clr_in, wstart_ff, wstart_in;
   logic [SEG_W-1:0]        gseg_ff, gseg_in, dstart_ff, dstart_in;
   logic [CNT_W-1:0]        f_ff, f_in, idx_ff, idx_in, n_ff, n_in, pos_ff, pos_in;
   logic                    pend_ff, pend_in, grow_ff, grow_in;
   logic [HEIGHT_W-1:0]     h_ff, h_in, wlog_ff, wlog_in, dlog_ff, dlog_in;
   logic [CMP_W-1:0]        lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic [SEGC_W-1:0]       gleft_ff, gleft_in, didx_ff, didx_in;
   logic [SHIFT_W-1:0]      gshift_ff, gshift_in, dshift_ff, dshift_in;
   logic [ADDR_W-1:0]       dest_ff, dest_in;
   logic [CNT_W-1:0]        rcnt_ff, rcnt_in;
   logic [KEY_W-1:0]        ksum_ff, ksum_in, vsum_ff, vsum_in;
   logic [KEY_W-1:0]        first_ff, first_in, last_ff, last_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]        rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [KEY_W-1:0]        rsp_ksum_ff, rsp_ksum_in, rsp_vsum_ff, rsp_vsum_in;
   logic [KEY_W-1:0]        rsp_first_ff, rsp_first_in, rsp_last_ff, rsp_last_in;

   logic                    kv_we, fill_we, sp_we;
   logic [ADDR_W-1:0]       kv_waddr, kv_raddr, sp_waddr, sp_raddr;
   logic [PAIR_W-1:0]       kv_wdata, kv_rdata, sp_wdata, sp_rdata;
   logic [SEG_W-1:0]        fill_waddr, fill_raddr;
   logic [CNT_W-1:0]        fill_wdata, fill_rdata;

   logic                    accept;
   logic [SHIFT_W-1:0]      segc_log;
   logic [CNT_W-1:0]        segsize;
   logic signed [KEY_W-1:0] rd_key;
   logic [SEG_W:0]          psum;
   logic                    full_rej, shift_more, in_range, lk_hit;
   logic                    issue, elem_done, sum_done, over, climb, grow_ok;
   logic [SHIFT_W-1:0]      newlog, nseg_log, nnew_log;
   logic [SHIFT_W:0]        rhs_shamt;
   logic [CNT_W-1:0]        wl, per, odd, fseg;
   logic [SEGC_W-1:0]       dcount;
   logic [DBASE_W+HEIGHT_W-1:0] rhs_mul;

   pma_ram #(.WIDTH(PAIR_W), .DEPTH(STORE_DEPTH)) u_kv_ram (
      .clock(clock), .wr_en(kv_we), .wr_addr(kv_waddr), .wr_data(kv_wdata),
      .rd_addr(kv_raddr), .rd_data(kv_rdata)
   );

   pma_ram #(.WIDTH(PAIR_W), .DEPTH(STORE_DEPTH)) u_spread_ram (
      .clock(clock), .wr_en(sp_we), .wr_addr(sp_waddr), .wr_data(sp_wdata),
      .rd_addr(sp_raddr), .rd_data(sp_rdata)
   );

   pma_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SEGMENTS)) u_fill_ram (
      .clock(clock), .wr_en(fill_we), .wr_addr(fill_waddr), .wr_data(fill_wdata),
      .rd_addr(fill_raddr), .rd_data(fill_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && (state_ff == S_IDLE);

   assign segc_log   = capshift_ff - segshift_ff;
   assign segsize    = CNT_W'(1) << segshift_ff;
   assign rd_key     = kv_rdata[PAIR_W-1:KEY_W];
   assign psum       = {1'b0, lb_ff} + {1'b0, ub_ff};
   assign full_rej   = (fill_rdata >= segsize) || (ecount_ff >= CNT_W'(STORE_DEPTH));
   assign shift_more = key_ff < rd_key;
   assign in_range   = (rd_key >= key_ff) && (rd_key <= hi_ff);
   assign lk_hit     = pend_ff && (rd_key == key_ff);
   assign issue      = idx_ff < f_ff;
   assign elem_done  = (idx_ff == f_ff) && !pend_ff;
   assign wl         = CNT_W'(1) << wlog_ff;
   assign sum_done   = (idx_ff == wl) && !pend_ff;

   assign rhs_shamt = {1'b0, SHIFT_W'(wlog_ff)} + {1'b0, segshift_ff};
   assign over      = (lhs_ff << 8) >= (rhs_ff << rhs_shamt);
   assign climb     = (h_ff < height_ff) && ((h_ff == HEIGHT_W'(1)) || over);

   assign newlog   = capshift_ff + SHIFT_W'(1);
   assign nseg_log = ceil_log(newlog);
   assign nnew_log = newlog - nseg_log;
   assign grow_ok  = (newlog <= SHIFT_W'(MAX_CAP_LOG)) && (nseg_log <= newlog) &&
                     (nnew_log <= SHIFT_W'(MAX_SEG_LOG));

   assign dcount = SEGC_W'(1) << dlog_ff;
   assign per    = n_ff >> dlog_ff;
   assign odd    = n_ff & ((CNT_W'(1) << dlog_ff) - CNT_W'(1));
   assign fseg   = per + ((CNT_W'(didx_ff) < odd) ? CNT_W'(1) : CNT_W'(0));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == SEG_W'(MAX_SEGMENTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_RANGE) begin
                  if (req_key <= req_high_key) state_in = S_GA_SEG;
               end else if (req_kind == KIND_INSERT || req_kind == KIND_LOOKUP) begin
                  state_in = (ecount_ff == '0) ? S_OP : S_LOC_TEST;
               end
            end
         end
         S_LOC_TEST:  state_in = (lb_ff < ub_ff) ? S_LOC_FIRST : S_OP;
         S_LOC_FIRST: state_in = (fill_rdata == '0 || key_ff < rd_key) ? S_LOC_TEST
                                                                        : S_LOC_LAST;
         S_LOC_LAST:  state_in = (key_ff <= rd_key) ? S_OP : S_LOC_TEST;
         S_OP: begin
            if (kind_ff == KIND_INSERT) begin
               if (full_rej)                state_in = S_IDLE;
               else if (fill_rdata != '0)   state_in = S_INS_SHIFT;
               else                         state_in = S_INS_PUT;
            end else begin
               state_in = S_LK_SCAN;
            end
         end
         S_INS_SHIFT: begin
            if (!(shift_more && idx_ff > CNT_W'(1))) state_in = S_INS_PUT;
         end
         S_INS_PUT:   state_in = (f_ff + CNT_W'(1) == segsize) ? S_REB_START : S_IDLE;
         S_LK_SCAN:   if (lk_hit || elem_done) state_in = S_IDLE;
         S_REB_START: state_in = S_DENS_MUL;
         S_DENS_MUL:  state_in = S_DENS_CMP;
         S_DENS_CMP:  state_in = climb ? S_WIN_SUM : S_GA_SEG;
         S_WIN_SUM:   if (sum_done) state_in = S_DENS_MUL;
         S_GA_SEG:    state_in = S_GA_FILL;
         S_GA_FILL:   state_in = S_GA_ELEM;
         S_GA_ELEM: begin
            if (elem_done) begin
               if (gleft_ff != SEGC_W'(1))     state_in = S_GA_SEG;
               else if (kind_ff == KIND_RANGE) state_in = S_IDLE;
               else                            state_in = S_DI_SEG;
            end
         end
         S_DI_SEG:    state_in = S_DI_ELEM;
         S_DI_ELEM: begin
            if (elem_done) begin
               state_in = (didx_ff + SEGC_W'(1) == dcount) ? S_IDLE : S_DI_SEG;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and memory ports
   always_comb begin
      kind_in = kind_ff;   key_in = key_ff;   val_in = val_ff;   hi_in = hi_ff;
      capshift_in = capshift_ff;  segshift_in = segshift_ff;  height_in = height_ff;
      ecount_in = ecount_ff;
      dbase_in  = (csr_valid && csr_ready) ? csr_data : dbase_ff;
      lb_in = lb_ff;  ub_in = ub_ff;  p_in = p_ff;  seg_in = seg_ff;  clr_in = clr_ff;
      wstart_in = wstart_ff;  gseg_in = gseg_ff;  dstart_in = dstart_ff;
      f_in = f_ff;  idx_in = idx_ff;  n_in = n_ff;  pos_in = pos_ff;
      pend_in = pend_ff;  grow_in = grow_ff;
      h_in = h_ff;  wlog_in = wlog_ff;  dlog_in = dlog_ff;
      lhs_in = lhs_ff;  rhs_in = rhs_ff;  rhs_mul = '0;
      gleft_in = gleft_ff;  didx_in = didx_ff;
      gshift_in = gshift_ff;  dshift_in = dshift_ff;  dest_in = dest_ff;
      rcnt_in = rcnt_ff;  ksum_in = ksum_ff;  vsum_in = vsum_ff;
      first_in = first_ff;  last_in = last_ff;

      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;  rsp_found_in = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;   rsp_ksum_in  = rsp_ksum_ff;
      rsp_vsum_in   = rsp_vsum_ff;    rsp_first_in = rsp_first_ff;
      rsp_last_in   = rsp_last_ff;

      kv_we = 1'b0;  kv_waddr = '0;  kv_wdata = '0;  kv_raddr = '0;
      sp_we = 1'b0;  sp_waddr = '0;  sp_wdata = '0;  sp_raddr = '0;
      fill_we = 1'b0;  fill_waddr = '0;  fill_wdata = '0;  fill_raddr = '0;

      case (state_ff)
         S_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            clr_in     = clr_ff + SEG_W'(1);
         end
         S_IDLE: begin
            if (accept) begin
               kind_in = req_kind;  key_in = req_key;
               val_in  = req_value; hi_in  = req_high_key;
               lb_in   = '0;
               ub_in   = SEG_W'((SEGC_W'(1) << segc_log) - SEGC_W'(1));
               seg_in  = '0;
               gseg_in   = '0;
               gleft_in  = SEGC_W'(1) << segc_log;
               gshift_in = segshift_ff;
               rcnt_in = '0;  ksum_in = '0;  vsum_in = '0;
               first_in = '0; last_in = '0;
               if (req_kind == KIND_RANGE && req_key > req_high_key) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_BAD_RANGE;
                  rsp_found_in  = '0;  rsp_count_in = '0;
                  rsp_ksum_in   = '0;  rsp_vsum_in  = '0;
                  rsp_first_in  = '0;  rsp_last_in  = '0;
               end
            end
         end
         S_LOC_TEST: begin
            if (lb_ff < ub_ff) begin
               p_in       = psum[SEG_W:1];
               fill_raddr = psum[SEG_W:1];
               kv_raddr   = slot_addr(psum[SEG_W:1], segshift_ff, '0);
            end else begin
               seg_in     = lb_ff;
               fill_raddr = lb_ff;
            end
         end
         S_LOC_FIRST: begin
            if (fill_rdata == '0 || key_ff < rd_key) begin
               ub_in = (p_ff == '0) ? '0 : p_ff - SEG_W'(1);
            end else begin
               kv_raddr = slot_addr(p_ff, segshift_ff, fill_rdata - CNT_W'(1));
            end
         end
         S_LOC_LAST: begin
            if (key_ff <= rd_key) begin
               seg_in     = p_ff;
               fill_raddr = p_ff;
            end else begin
               lb_in = p_ff + SEG_W'(1);
            end
         end
         S_OP: begin
            f_in    = fill_rdata;
            pend_in = 1'b0;
            if (kind_ff == KIND_INSERT) begin
               idx_in = fill_rdata;
               if (full_rej) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_FULL;
                  rsp_found_in  = '0;  rsp_count_in = '0;
                  rsp_ksum_in   = '0;  rsp_vsum_in  = '0;
                  rsp_first_in  = '0;  rsp_last_in  = '0;
               end else if (fill_rdata != '0) begin
                  kv_raddr = slot_addr(seg_ff, segshift_ff, fill_rdata - CNT_W'(1));
               end
            end else begin
               idx_in = '0;
            end
         end
         S_INS_SHIFT: begin
            if (shift_more) begin
               kv_we    = 1'b1;
               kv_waddr = slot_addr(seg_ff, segshift_ff, idx_ff);
               kv_wdata = kv_rdata;
               idx_in   = idx_ff - CNT_W'(1);
               kv_raddr = slot_addr(seg_ff, segshift_ff, idx_ff - CNT_W'(2));
            end
         end
         S_INS_PUT: begin
            kv_we      = 1'b1;
            kv_waddr   = slot_addr(seg_ff, segshift_ff, idx_ff);
            kv_wdata   = {key_ff, val_ff};
            fill_we    = 1'b1;
            fill_waddr = seg_ff;
            fill_wdata = f_ff + CNT_W'(1);
            ecount_in  = ecount_ff + CNT_W'(1);
            if (f_ff + CNT_W'(1) != segsize) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_found_in  = '0;  rsp_count_in = '0;
               rsp_ksum_in   = '0;  rsp_vsum_in  = '0;
               rsp_first_in  = '0;  rsp_last_in  = '0;
            end
         end
         S_LK_SCAN: begin
            pend_in = issue;
            if (issue) begin
               kv_raddr = slot_addr(seg_ff, segshift_ff, idx_ff);
               idx_in   = idx_ff + CNT_W'(1);
            end
            if (lk_hit || elem_done) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = lk_hit ? STAT_OK : STAT_MISS;
               rsp_found_in  = lk_hit ? kv_rdata[KEY_W-1:0] : '1;
               rsp_count_in  = '0;  rsp_ksum_in = '0;  rsp_vsum_in = '0;
               rsp_first_in  = '0;  rsp_last_in = '0;
            end
         end
         S_REB_START: begin
            h_in      = HEIGHT_W'(1);
            wlog_in   = '0;
            wstart_in = seg_ff;
            n_in      = segsize;
         end
         S_DENS_MUL: begin
            rhs_mul = dbase_ff * height_ff;
            lhs_in  = CMP_W'(n_ff * height_ff);
            rhs_in  = CMP_W'(rhs_mul) + (CMP_W'(height_ff - h_ff) << 6);
         end
         S_DENS_CMP: begin
            pos_in = '0;
            if (climb) begin
               h_in      = h_ff + HEIGHT_W'(1);
               wlog_in   = wlog_ff + HEIGHT_W'(1);
               wstart_in = (seg_ff >> (wlog_ff + HEIGHT_W'(1))) << (wlog_ff + HEIGHT_W'(1));
               idx_in    = '0;
               pend_in   = 1'b0;
               n_in      = '0;
            end else if (over && grow_ok) begin
               grow_in   = 1'b1;
               gseg_in   = '0;
               gleft_in  = SEGC_W'(1) << segc_log;
               gshift_in = segshift_ff;
               dstart_in = '0;
               dlog_in   = HEIGHT_W'(nnew_log);
               dshift_in = nseg_log;
            end else begin
               grow_in   = 1'b0;
               gseg_in   = wstart_ff;
               gleft_in  = SEGC_W'(1) << wlog_ff;
               gshift_in = segshift_ff;
               dstart_in = wstart_ff;
               dlog_in   = wlog_ff;
               dshift_in = segshift_ff;
            end
         end
         S_WIN_SUM: begin
            pend_in = idx_ff < wl;
            if (idx_ff < wl) begin
               fill_raddr = wstart_ff + SEG_W'(idx_ff);
               idx_in     = idx_ff + CNT_W'(1);
            end
            if (pend_ff) n_in = n_ff + fill_rdata;
         end
         S_GA_SEG: begin
            fill_raddr = gseg_ff;
         end
         S_GA_FILL: begin
            f_in    = fill_rdata;
            idx_in  = '0;
            pend_in = 1'b0;
         end
         S_GA_ELEM: begin
            pend_in = issue;
            if (issue) begin
               kv_raddr = slot_addr(gseg_ff, gshift_ff, idx_ff);
               idx_in   = idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (kind_ff == KIND_RANGE) begin
                  if (in_range) begin
                     if (rcnt_ff == '0) first_in = rd_key;
                     last_in = rd_key;
                     ksum_in = ksum_ff + rd_key;
                     vsum_in = vsum_ff + kv_rdata[KEY_W-1:0];
                     rcnt_in = rcnt_ff + CNT_W'(1);
                  end
               end else begin
                  sp_we    = 1'b1;
                  sp_waddr = pos_ff[ADDR_W-1:0];
                  sp_wdata = kv_rdata;
                  pos_in   = pos_ff + CNT_W'(1);
               end
            end
            if (elem_done) begin
               gseg_in  = gseg_ff + SEG_W'(1);
               gleft_in = gleft_ff - SEGC_W'(1);
               if (gleft_ff == SEGC_W'(1)) begin
                  n_in    = pos_ff;
                  pos_in  = '0;
                  didx_in = '0;
                  if (kind_ff == KIND_RANGE) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = (rcnt_ff == '0) ? STAT_MISS : STAT_OK;
                     rsp_found_in  = '0;
                     rsp_count_in  = COUNT_W'(rcnt_ff);
                     rsp_ksum_in   = ksum_ff;
                     rsp_vsum_in   = vsum_ff;
                     rsp_first_in  = first_ff;
                     rsp_last_in   = last_ff;
                  end
               end
            end
         end
         S_DI_SEG: begin
            fill_we    = 1'b1;
            fill_waddr = dstart_ff + SEG_W'(didx_ff);
            fill_wdata = fseg;
            f_in       = fseg;
            idx_in     = '0;
            pend_in    = 1'b0;
         end
         S_DI_ELEM: begin
            pend_in = issue;
            if (issue) begin
               sp_raddr = pos_ff[ADDR_W-1:0];
               pos_in   = pos_ff + CNT_W'(1);
               dest_in  = slot_addr(dstart_ff + SEG_W'(didx_ff), dshift_ff, idx_ff);
               idx_in   = idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               kv_we    = 1'b1;
               kv_waddr = dest_ff;
               kv_wdata = sp_rdata;
            end
            if (elem_done) begin
               didx_in = didx_ff + SEGC_W'(1);
               if (didx_ff + SEGC_W'(1) == dcount) begin
                  if (grow_ff) begin
                     capshift_in = capshift_ff + SHIFT_W'(1);
                     segshift_in = dshift_ff;
                     height_in   = dlog_ff + HEIGHT_W'(1);
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_OK;
                  rsp_found_in  = '0;  rsp_count_in = '0;
                  rsp_ksum_in   = '0;  rsp_vsum_in  = '0;
                  rsp_first_in  = '0;  rsp_last_in  = '0;
               end
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         capshift_ff  <= SHIFT_W'(MIN_CAP_LOG);
         segshift_ff  <= SHIFT_W'(MIN_CAP_LOG);
         height_ff    <= HEIGHT_W'(1);
         ecount_ff    <= '0;
         dbase_ff     <= DBASE_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         capshift_ff  <= capshift_in;
         segshift_ff  <= segshift_in;
         height_ff    <= height_in;
         ecount_ff    <= ecount_in;
         dbase_ff     <= dbase_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;    key_ff   <= key_in;    val_ff <= val_in;  hi_ff <= hi_in;
      lb_ff     <= lb_in;      ub_ff    <= ub_in;     p_ff   <= p_in;    seg_ff <= seg_in;
      wstart_ff <= wstart_in;  gseg_ff  <= gseg_in;   dstart_ff <= dstart_in;
      f_ff      <= f_in;       idx_ff   <= idx_in;    n_ff   <= n_in;    pos_ff <= pos_in;
      grow_ff   <= grow_in;    h_ff     <= h_in;      wlog_ff <= wlog_in;
      dlog_ff   <= dlog_in;    lhs_ff   <= lhs_in;    rhs_ff <= rhs_in;
      gleft_ff  <= gleft_in;   didx_ff  <= didx_in;
      gshift_ff <= gshift_in;  dshift_ff <= dshift_in; dest_ff <= dest_in;
      rcnt_ff   <= rcnt_in;    ksum_ff  <= ksum_in;   vsum_ff <= vsum_in;
      first_ff  <= first_in;   last_ff  <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ksum_ff   <= rsp_ksum_in;
      rsp_vsum_ff   <= rsp_vsum_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_value    = rsp_found_ff;
   assign rsp_match_count    = rsp_count_ff;
   assign rsp_key_total      = rsp_ksum_ff;
   assign rsp_value_total    = rsp_vsum_ff;
   assign rsp_first_in_range = rsp_first_ff;
   assign rsp_last_in_range  = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_fits: assert property (@(posedge clock) disable iff (reset)
      ecount_ff <= (CNT_W'(1) << capshift_ff))
      else $error("element count exceeds capacity");

   a_seg_fits: assert property (@(posedge clock) disable iff (reset)
      segshift_ff <= capshift_ff)
      else $error("segment larger than array");

   a_insert_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_INSERT) |=> busy)
      else $error("insert accepted without going busy");

   a_height_fits: assert property (@(posedge clock) disable iff (reset)
      height_ff <= HEIGHT_W'(MAX_SEG_LOG + 1))
      else $error("tree height out of range");
`endif

endmodule

### rtl/pma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pma_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### verif/packed_memory_array_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed memory array testbench
// Drives inserts, lookups and range sums through the command port, runs the
// store under several density thresholds, and checks every response word
// against a behavioural copy of the store kept inside a small scoreboard.
// ----------------------------------------------------------------------------
module packed_memory_array_top_tb;
   import pma_pkg::*;

   typedef struct packed {
      logic [1:0]         status;
      logic [63:0]        found;
      logic [COUNT_W-1:0] count;
      logic [63:0]        key_sum;
      logic [63:0]        val_sum;
      logic [63:0]        first;
      logic [63:0]        last;
   } answer_t;

   class pma_scoreboard;
      longint      keys [STORE_DEPTH];
      logic [63:0] vals [STORE_DEPTH];
      longint      tmp_keys [STORE_DEPTH];
      logic [63:0] tmp_vals [STORE_DEPTH];
      int unsigned fill [MAX_SEGMENTS];
      int unsigned capacity, seg_size, height, n_elems, dbase;
      answer_t     answers [$];
      int          mismatches;
      int          strays;

      function new();
         foreach (keys[i]) begin
            keys[i] = 0;
            vals[i] = '0;
         end
         foreach (fill[i]) fill[i] = 0;
         capacity   = MIN_CAPACITY;
         seg_size   = MIN_CAPACITY;
         height     = 1;
         n_elems    = 0;
         dbase      = DBASE_RESET;
         mismatches = 0;
         strays     = 0;
      endfunction

      function int unsigned log2f(int unsigned x);
         int unsigned r;
         r = 0;
         while (x > 1) begin
            x = x >> 1;
            r++;
         end
         return r;
      endfunction

      function int unsigned pow2c(int unsigned x);
         int unsigned p;
         p = 1;
         while (p < x) p = p << 1;
         return p;
      endfunction

      function int unsigned find_segment(longint k);
         int unsigned lo, hi, mid, f, b;
         lo = 0;
         if (n_elems == 0) return 0;
         hi = capacity / seg_size - 1;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            f   = fill[mid];
            b   = mid * seg_size;
            if (f == 0 || k < keys[b]) begin
               hi = (mid == 0) ? 0 : mid - 1;
            end else if (k <= keys[b + f - 1]) begin
               return mid;
            end else begin
               lo = mid + 1;
            end
         end
         return lo;
      endfunction

      function bit over_density(int unsigned n, int unsigned wl, int unsigned h);
         longint unsigned hh, lhs, rhs;
         hh  = height;
         lhs = longint'(n) * 256 * hh;
         rhs = (longint'(dbase) * hh + 64 * (hh - h)) * wl * seg_size;
         return lhs >= rhs;
      endfunction

      function void even_out(int unsigned first_seg, int unsigned wl);
         int unsigned pos, per, odd, sg;
         pos = 0;
         for (int unsigned s = first_seg; s < first_seg + wl; s++)
            for (int unsigned j = 0; j < fill[s]; j++) begin
               tmp_keys[pos] = keys[s * seg_size + j];
               tmp_vals[pos] = vals[s * seg_size + j];
               pos++;
            end
         per = pos / wl;
         odd = pos % wl;
         pos = 0;
         for (int unsigned s = 0; s < wl; s++) begin
            sg = first_seg + s;
            fill[sg] = per + ((s < odd) ? 1 : 0);
            for (int unsigned j = 0; j < fill[sg]; j++) begin
               keys[sg * seg_size + j] = tmp_keys[pos];
               vals[sg * seg_size + j] = tmp_vals[pos];
               pos++;
            end
         end
      endfunction

      function bit double_capacity();
         int unsigned newcap, newseg, nseg, pos, per, odd;
         newcap = capacity * 2;
         if (newcap > MAX_CAPACITY) return 0;
         newseg = pow2c(log2f(newcap));
         nseg   = newcap / newseg;
         if (nseg == 0 || nseg > MAX_SEGMENTS) return 0;
         pos = 0;
         for (int unsigned s = 0; s < capacity / seg_size; s++)
            for (int unsigned j = 0; j < fill[s]; j++) begin
               tmp_keys[pos] = keys[s * seg_size + j];
               tmp_vals[pos] = vals[s * seg_size + j];
               pos++;
            end
         per = pos / nseg;
         odd = pos % nseg;
         pos = 0;
         for (int unsigned s = 0; s < nseg; s++) begin
            fill[s] = per + ((s < odd) ? 1 : 0);
            for (int unsigned j = 0; j < fill[s]; j++) begin
               keys[s * newseg + j] = tmp_keys[pos];
               vals[s * newseg + j] = tmp_vals[pos];
               pos++;
            end
         end
         capacity = newcap;
         seg_size = newseg;
         height   = log2f(nseg) + 1;
         return 1;
      endfunction

      function void rebalance(int unsigned seg);
         int unsigned h, wl, wid, first_seg, n;
         bit over;
         h = 1;
         wl = 1;
         wid = seg;
         first_seg = seg;
         over = over_density(fill[seg], 1, 1);
         if (height > 1) begin
            do begin
               h++;
               wl  = wl * 2;
               wid = wid / 2;
               first_seg = wid * wl;
               n = 0;
               for (int unsigned s = first_seg; s < first_seg + wl; s++) n += fill[s];
               over = over_density(n, wl, h);
            end while (over && h < height);
         end
         if (over && double_capacity()) return;
         even_out(first_seg, wl);
      endfunction

      function void note_command(logic [1:0] kind, longint k, logic [63:0] v,
                                 longint hk);
         answer_t     a;
         int unsigned seg, b, f, i, cnt;
         longint      kk;
         a = '0;
         if (kind == KIND_INSERT) begin
            seg = find_segment(k);
            f = fill[seg];
            if (f >= seg_size || n_elems >= STORE_DEPTH) begin
               a.status = STAT_FULL;
            end else begin
               b = seg * seg_size;
               i = f;
               while (i > 0 && k < keys[b + i - 1]) begin
                  keys[b + i] = keys[b + i - 1];
                  vals[b + i] = vals[b + i - 1];
                  i--;
               end
               keys[b + i] = k;
               vals[b + i] = v;
               fill[seg] = f + 1;
               n_elems++;
               if (fill[seg] == seg_size) rebalance(seg);
            end
         end else if (kind == KIND_LOOKUP) begin
            seg = find_segment(k);
            b = seg * seg_size;
            a.status = STAT_MISS;
            a.found  = '1;
            for (i = 0; i < fill[seg]; i++)
               if (keys[b + i] == k) begin
                  a.status = STAT_OK;
                  a.found  = vals[b + i];
                  break;
               end
         end else if (kind == KIND_RANGE) begin
            if (k > hk) begin
               a.status = STAT_BAD_RANGE;
            end else begin
               cnt = 0;
               for (int unsigned s = 0; s < capacity / seg_size; s++)
                  for (int unsigned j = 0; j < fill[s]; j++) begin
                     kk = keys[s * seg_size + j];
                     if (kk >= k && kk <= hk) begin
                        if (cnt == 0) a.first = kk;
                        a.last    = kk;
                        a.key_sum = a.key_sum + kk;
                        a.val_sum = a.val_sum + vals[s * seg_size + j];
                        cnt++;
                     end
                  end
               a.status = (cnt != 0) ? STAT_OK : STAT_MISS;
               a.count  = cnt[COUNT_W-1:0];
            end
         end else begin
            return;
         end
         answers.push_back(a);
      endfunction

      function void check_answer(answer_t got);
         answer_t want;
         if (answers.size() == 0) begin
            strays++;
            if (mismatches + strays <= 10)
               $display("unexpected response word status=%0d", got.status);
            return;
         end
         want = answers.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches + strays <= 10)
               $display("mismatch: exp st=%0d fv=%0h n=%0d ks=%0h vs=%0h f=%0h l=%0h | got st=%0d fv=%0h n=%0d ks=%0h vs=%0h f=%0h l=%0h",
                        want.status, want.found, want.count, want.key_sum,
                        want.val_sum, want.first, want.last,
                        got.status, got.found, got.count, got.key_sum,
                        got.val_sum, got.first, got.last);
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [1:0]              req_kind;
   logic signed [KEY_W-1:0] req_key, req_value, req_high_key;
   logic                    rsp_valid;
   logic [1:0]              rsp_status;
   logic signed [KEY_W-1:0] rsp_found_value, rsp_key_total, rsp_value_total;
   logic [COUNT_W-1:0]      rsp_match_count;
   logic signed [KEY_W-1:0] rsp_first_in_range, rsp_last_in_range;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [DBASE_W-1:0]      csr_data;

   pma_scoreboard sb;
   bit            quiet;

   packed_memory_array_top u_top (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_answer({rsp_status, rsp_found_value, rsp_match_count,
                          rsp_key_total, rsp_value_total,
                          rsp_first_in_range, rsp_last_in_range});
   end

   initial begin
      #30_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic send(logic [1:0] kind, longint k, longint v, longint hk);
      req_kind     <= kind;
      req_key      <= k;
      req_value    <= v;
      req_high_key <= hk;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_command(kind, k, v, hk);
   endtask

   task automatic pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.answers.size() != 0) @(posedge clock);
      @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(logic [DBASE_W-1:0] d);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.dbase = d;
   endtask

   function automatic longint pick_key();
      case ($urandom_range(0, 9))
         0:       return {$urandom, $urandom};
         1:       return $urandom_range(0, 1) ? 64'h7fff_ffff_ffff_ffff
                                              : 64'h8000_0000_0000_0000;
         2, 3:    return longint'($urandom_range(0, 4000)) - 2000;
         default: return longint'($urandom_range(0, 60)) - 30;
      endcase
   endfunction

   task automatic random_item();
      int     r;
      longint a, b;
      r = $urandom_range(0, 99);
      a = pick_key();
      if (r < 55) begin
         send(KIND_INSERT, a, {$urandom, $urandom}, {$urandom, $urandom});
      end else if (r < 78) begin
         send(KIND_LOOKUP, a, {$urandom, $urandom}, {$urandom, $urandom});
      end else if (r < 95) begin
         b = pick_key();
         if ($urandom_range(0, 7) != 0 && a > b) send(KIND_RANGE, b, {$urandom, $urandom}, a);
         else send(KIND_RANGE, a, {$urandom, $urandom}, b);
      end else begin
         send(2'd3, a, {$urandom, $urandom}, {$urandom, $urandom});
         return;
      end
      if (!quiet && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 12));
   endtask

   localparam longint KMAX = 64'h7fff_ffff_ffff_ffff;
   localparam longint KMIN = 64'h8000_0000_0000_0000;

   initial begin
      logic [DBASE_W-1:0] phases [5];
      sb = new();
      quiet = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_INSERT;
      req_key = '0;
      req_value = '0;
      req_high_key = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_threshold(9'd192);
      send(KIND_LOOKUP, 5, 0, 0);
      send(KIND_RANGE, KMIN, 0, KMAX);
      send(KIND_INSERT, KMAX, -1, 0);
      send(KIND_INSERT, KMIN, KMIN, 0);
      send(KIND_INSERT, 0, KMAX, 0);
      send(KIND_INSERT, 7, 11, 0);
      send(KIND_INSERT, 7, 22, 0);
      send(KIND_INSERT, -7, 33, 0);
      send(2'd3, 9, 9, 9);
      send(KIND_LOOKUP, 7, 0, 0);
      send(KIND_LOOKUP, KMAX, 0, 0);
      send(KIND_LOOKUP, KMIN, 0, 0);
      send(KIND_LOOKUP, 8, 0, 0);
      send(KIND_RANGE, KMIN, 0, KMAX);
      send(KIND_RANGE, 7, 0, 7);
      send(KIND_RANGE, 8, 0, 6);
      send(KIND_RANGE, 1, 0, 6);
      send(KIND_RANGE, KMAX, 0, KMAX);
      send(KIND_LOOKUP, -7, 0, 0);
      send(KIND_INSERT, -1, -1, -1);

      // Fill
      phases = '{9'd192, 9'd256, 9'd1, 9'd100, 9'd511};
      for (int p = 0; p < 5; p++) begin
         write_threshold(phases[p]);
         for (int i = 0; i < 230; i++) begin
            if (p == 4 && i >= 80) quiet = 1'b1;
            if (p == 1 && i == 100) drain();
            random_item();
         end
      end

      drain();
      repeat (50) @(posedge clock);
      if (sb.mismatches == 0 && sb.strays == 0 && sb.answers.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
rtl/pma_pkg.sv
rtl/pma_ram.sv
rtl/packed_memory_array_top.sv
verif/packed_memory_array_top_tb.sv
